// ----- rtl/psd_pkg.sv -----
// Shared definitions for the point to segment distance block.
// Holds default widths, the queue depth and the queue status type; no dependencies.
package psd_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int EXTRA_FRAC_BITS_DEF = 8;
    localparam int DIST_BITS           = 25;
    localparam int FIFO_DEPTH          = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ----- rtl/psd_req_if.sv -----
// Request channel carrying segment endpoints and a query point.
// Depends on psd_pkg for the default coordinate width.
interface psd_req_if #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, query_x, query_y,
        output ready
    );
endinterface

// ----- rtl/psd_rsp_if.sv -----
// Response channel carrying the range flag and the scaled distance.
// Depends on psd_pkg for the distance width.
interface psd_rsp_if ();
    logic                           valid;
    logic                           ready;
    logic                           in_range;
    logic [psd_pkg::DIST_BITS-1:0]  distance;

    modport source (output valid, in_range, distance, input ready);
    modport sink   (input valid, in_range, distance, output ready);
endinterface

// ----- rtl/psd_fifo.sv -----
// Short queue between the front and back pipelines of the distance block.
// Depends on psd_pkg for its depth and status type.
module psd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output psd_pkg::fifo_status_t status
);
    import psd_pkg::*;

    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_BITS'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- rtl/psd_front.sv -----
// Front pipeline: differences, products, range test and squared cross product.
// Depends on psd_pkg and psd_req_if; feeds psd_fifo.
module psd_front #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = psd_pkg::EXTRA_FRAC_BITS_DEF,
    parameter int FW              = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    psd_req_if.sink               req,
    input  psd_pkg::fifo_status_t status,
    output logic                  push,
    output logic [FW-1:0]         wr_data
);
    import psd_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int LW  = 2 * DW;
    localparam int CW  = 2 * DW;
    localparam int HW  = DW;
    localparam int SQW = 2 * CW;
    localparam int C2W = SQW + 2 * EXTRA_FRAC_BITS;

    logic en;
    logic va_reg, vb_reg, vc_reg, vd_reg;

    logic signed [DW-1:0] dx_reg, dy_reg, lx_reg, ly_reg;
    logic signed [DW-1:0] dx_next, dy_next, lx_next, ly_next;

    logic signed [PW-1:0] pxl_reg, pyl_reg, pxx_reg, pyy_reg, pxly_reg, pylx_reg;
    logic signed [PW-1:0] pxl_next, pyl_next, pxx_next, pyy_next, pxly_next, pylx_next;

    logic signed [PW:0]   dot_sum, len2_sum, cross_sum;
    logic [LW-1:0]        len2_reg, len2_next;
    logic [CW-1:0]        mag_reg, mag_next;
    logic                 inr_reg, inr_next;

    logic [2*HW-1:0]      hh_reg, hl_reg, ll_reg;
    logic [LW-1:0]        len2_d_reg;
    logic                 inr_d_reg;
    logic [SQW-1:0]       sq;
    logic [C2W-1:0]       c2;

    assign en        = !vd_reg || !status.full;
    assign req.ready = en;
    assign push      = vd_reg && !status.full;

    always_comb
    begin
        dx_next   = DW'(req.end_x)   - DW'(req.start_x);
        dy_next   = DW'(req.end_y)   - DW'(req.start_y);
        lx_next   = DW'(req.query_x) - DW'(req.start_x);
        ly_next   = DW'(req.query_y) - DW'(req.start_y);
        pxl_next  = dx_reg * lx_reg;
        pyl_next  = dy_reg * ly_reg;
        pxx_next  = dx_reg * dx_reg;
        pyy_next  = dy_reg * dy_reg;
        pxly_next = dx_reg * ly_reg;
        pylx_next = dy_reg * lx_reg;
        dot_sum   = (PW+1)'(pxl_reg) + (PW+1)'(pyl_reg);
        len2_sum  = (PW+1)'(pxx_reg) + (PW+1)'(pyy_reg);
        cross_sum = (PW+1)'(pxly_reg) - (PW+1)'(pylx_reg);
        len2_next = len2_sum[LW-1:0];
        inr_next  = (len2_sum != '0) && !dot_sum[PW] && (dot_sum <= len2_sum);
        if (cross_sum[PW])
        begin
            mag_next = CW'(-cross_sum);
        end
        else
        begin
            mag_next = cross_sum[CW-1:0];
        end
        sq = {hh_reg, {(2*HW){1'b0}}} + (SQW'(hl_reg) << (HW + 1)) + SQW'(ll_reg);
        c2 = C2W'(sq) << (2 * EXTRA_FRAC_BITS);
    end

    assign wr_data = {inr_d_reg, len2_d_reg, c2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= req.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            lx_reg     <= lx_next;
            ly_reg     <= ly_next;
            pxl_reg    <= pxl_next;
            pyl_reg    <= pyl_next;
            pxx_reg    <= pxx_next;
            pyy_reg    <= pyy_next;
            pxly_reg   <= pxly_next;
            pylx_reg   <= pylx_next;
            len2_reg   <= len2_next;
            mag_reg    <= mag_next;
            inr_reg    <= inr_next;
            hh_reg     <= mag_reg[CW-1:HW] * mag_reg[CW-1:HW];
            hl_reg     <= mag_reg[CW-1:HW] * mag_reg[HW-1:0];
            ll_reg     <= mag_reg[HW-1:0] * mag_reg[HW-1:0];
            len2_d_reg <= len2_reg;
            inr_d_reg  <= inr_reg;
        end
    end

endmodule

// ----- rtl/psd_back.sv -----
// Back pipeline: one distance bit per stage by a restoring square-root-over-length recurrence.
// Depends on psd_pkg and psd_rsp_if; drains psd_fifo.
module psd_back #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = psd_pkg::EXTRA_FRAC_BITS_DEF,
    parameter int FW              = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FW-1:0]         rd_data,
    input  psd_pkg::fifo_status_t status,
    output logic                  pop,
    psd_rsp_if.source             rsp
);
    import psd_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int LW  = 2 * DW;
    localparam int C2W = 4 * DW + 2 * EXTRA_FRAC_BITS;
    localparam int MW  = LW + DIST_BITS;
    localparam int W   = ((C2W > LW + 2 * DIST_BITS) ? C2W : LW + 2 * DIST_BITS) + 1;

    logic                 en;
    logic                 vld_reg [DIST_BITS];
    logic                 inr_reg [DIST_BITS];
    logic [LW-1:0]        len2_reg [DIST_BITS];
    logic [W-1:0]         rem_reg [DIST_BITS];
    logic [MW-1:0]        m_reg [DIST_BITS];
    logic [DIST_BITS-1:0] r_reg [DIST_BITS];

    logic                 head_inr;
    logic [LW-1:0]        head_len2;
    logic [C2W-1:0]       head_c2;

    assign {head_inr, head_len2, head_c2} = rd_data;
    assign en  = !vld_reg[DIST_BITS-1] || rsp.ready;
    assign pop = en && !status.empty;

    for (genvar k = 0; k < DIST_BITS; k++)
    begin : g_stage
        localparam int B = DIST_BITS - 1 - k;
        logic                 vld_in, inr_in;
        logic [LW-1:0]        len2_in;
        logic [W-1:0]         rem_in, rem_next, trial;
        logic [MW-1:0]        m_in, m_next;
        logic [DIST_BITS-1:0] r_in, r_next;

        if (k == 0)
        begin : g_head
            assign vld_in  = !status.empty;
            assign inr_in  = head_inr;
            assign len2_in = head_len2;
            assign rem_in  = W'(head_c2);
            assign m_in    = '0;
            assign r_in    = '0;
        end
        else
        begin : g_chain
            assign vld_in  = vld_reg[k-1];
            assign inr_in  = inr_reg[k-1];
            assign len2_in = len2_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign m_in    = m_reg[k-1];
            assign r_in    = r_reg[k-1];
        end

        always_comb
        begin
            trial    = (W'(m_in) << (B + 1)) + (W'(len2_in) << (2 * B));
            rem_next = rem_in;
            m_next   = m_in;
            r_next   = r_in;
            if (trial <= rem_in)
            begin
                rem_next = rem_in - trial;
                m_next   = m_in + (MW'(len2_in) << B);
                r_next   = r_in | (DIST_BITS'(1) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                inr_reg[k]  <= inr_in;
                len2_reg[k] <= len2_in;
                rem_reg[k]  <= rem_next;
                m_reg[k]    <= m_next;
                r_reg[k]    <= r_next;
            end
        end
    end

    assign rsp.valid    = vld_reg[DIST_BITS-1];
    assign rsp.in_range = inr_reg[DIST_BITS-1];
    assign rsp.distance = inr_reg[DIST_BITS-1] ? r_reg[DIST_BITS-1] : '0;

`ifndef SYNTH
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.in_range |-> rsp.distance == '0)
        else $error("distance not cleared for an out-of-range result");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");

    a_degenerate_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && len2_reg[0] == '0 |-> !inr_reg[0])
        else $error("degenerate segment flagged in range");
`endif

endmodule

// ----- rtl/point_segment_distance.sv -----
// Top level of the point to segment distance block.
// Depends on psd_pkg, psd_req_if, psd_rsp_if, psd_front, psd_fifo and psd_back.
//
// Takes one query per clock and returns one result per clock when the response side is
// ready. Four front stages compute the differences, products, range test and squared cross
// product; results then pass through the queue and one back stage per distance bit. A
// stalled response side freezes the back stages and fills the queue before the request side
// sees ready fall.
module point_segment_distance #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = psd_pkg::EXTRA_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    psd_req_if.sink   req,
    psd_rsp_if.source rsp
);
    import psd_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int C2W = 4 * DW + 2 * EXTRA_FRAC_BITS;
    localparam int FW  = 1 + 2 * DW + C2W;

    logic         push, pop;
    logic [FW-1:0] wr_data, rd_data;
    fifo_status_t status;

    psd_front #(
        .COORD_BITS      (COORD_BITS),
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .FW              (FW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .status  (status),
        .push    (push),
        .wr_data (wr_data)
    );

    psd_fifo #(
        .WIDTH (FW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (rd_data),
        .status  (status)
    );

    psd_back #(
        .COORD_BITS      (COORD_BITS),
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .FW              (FW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (rd_data),
        .status  (status),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

// ----- tb/point_segment_distance_tb.sv -----
// Testbench for the point to segment distance block: random and directed queries, with
// results predicted by exact integer arithmetic and checked in order.
// Depends on psd_pkg, psd_req_if, psd_rsp_if and point_segment_distance.
module point_segment_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psd_pkg::*;

    typedef struct {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] query_x;
        logic signed [15:0] query_y;
    } query_t;

    typedef struct {
        logic                 in_range;
        logic [DIST_BITS-1:0] distance;
    } answer_t;

    logic clk;
    logic rst_n;
    psd_req_if #(.COORD_BITS(16)) req ();
    psd_rsp_if rsp ();

    point_segment_distance u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    query_t  pending_queries[$];
    answer_t expected_answers[$];
    int      mismatches;
    int      cycle_count;
    bit      req_accepted;
    bit      sender_busy_idle;
    bit      sender_quiet;
    bit      receiver_quiet;
    int      hold_off;
    int      hold_off_requests;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic answer_t predict_distance(query_t q);
        answer_t              a;
        longint               dx;
        longint               dy;
        longint               lx;
        longint               ly;
        longint               dot;
        longint               len2;
        longint               crs;
        logic [127:0]         c2;
        logic [127:0]         lhs;
        logic [DIST_BITS-1:0] r;
        logic [DIST_BITS-1:0] cand;
        dx = longint'(q.end_x) - longint'(q.start_x);
        dy = longint'(q.end_y) - longint'(q.start_y);
        lx = longint'(q.query_x) - longint'(q.start_x);
        ly = longint'(q.query_y) - longint'(q.start_y);
        dot = dx * lx + dy * ly;
        len2 = dx * dx + dy * dy;
        a.in_range = 1'b0;
        a.distance = '0;
        if (len2 == 0 || dot < 0 || dot > len2)
        begin
            return a;
        end
        crs = dx * ly - dy * lx;
        if (crs < 0)
        begin
            crs = -crs;
        end
        c2 = (128'(crs) * 128'(crs)) << 16;
        r = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--)
        begin
            cand = r | (DIST_BITS'(1) << b);
            lhs = 128'(cand) * 128'(cand) * 128'(len2);
            if (lhs <= c2)
            begin
                r = cand;
            end
        end
        a.in_range = 1'b1;
        a.distance = r;
        return a;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     t;
        int     s;
        q.start_x = pick_coord();
        q.start_y = pick_coord();
        q.end_x = pick_coord();
        q.end_y = pick_coord();
        q.query_x = 16'($urandom);
        q.query_y = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            // Aim the query near the segment so most land in range.
            t = $urandom_range(0, 256);
            s = $urandom_range(0, 8);
            q.query_x = 16'(int'(q.start_x) + ((int'(q.end_x) - int'(q.start_x)) * t) / 256
                        + (int'($urandom) >>> (24 + s)));
            q.query_y = 16'(int'(q.start_y) + ((int'(q.end_y) - int'(q.start_y)) * t) / 256
                        + (int'($urandom) >>> (24 + s)));
        end
        return q;
    endfunction

    function automatic query_t make_query(int ax, int ay, int bx, int by, int px, int py);
        query_t q;
        q.start_x = 16'(ax);
        q.start_y = 16'(ay);
        q.end_x = 16'(bx);
        q.end_y = 16'(by);
        q.query_x = 16'(px);
        q.query_y = 16'(py);
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_queries.size() != 0 || expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (!req.valid || req_accepted)
        begin
            if (pending_queries.size() != 0 && !sender_busy_idle
                && (sender_quiet || $urandom_range(0, 99) >= 20))
            begin
                req.valid <= 1'b1;
                req.start_x <= pending_queries[0].start_x;
                req.start_y <= pending_queries[0].start_y;
                req.end_x <= pending_queries[0].end_x;
                req.end_y <= pending_queries[0].end_y;
                req.query_x <= pending_queries[0].query_x;
                req.query_y <= pending_queries[0].query_y;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        req_accepted <= rst_n && req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
        begin
            void'(pending_queries.pop_front());
            expected_answers.push_back(predict_distance('{req.start_x, req.start_y, req.end_x,
                                                          req.end_y, req.query_x, req.query_y}));
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_off <= 0;
        end
        else if (hold_off_requests != 0 && hold_off == 0)
        begin
            hold_off <= 200;
            hold_off_requests <= hold_off_requests - 1;
            rsp.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= receiver_quiet || $urandom_range(0, 99) >= 20;
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected transaction: in_range=%0b distance=%0d",
                             rsp.in_range, rsp.distance);
                end
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp.in_range !== want.in_range || rsp.distance !== want.distance)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected in_range=%0b distance=%0d, got %0b %0d",
                                 want.in_range, want.distance, rsp.in_range, rsp.distance);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycle_count = 0;
        req_accepted = 1'b0;
        sender_busy_idle = 1'b0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        hold_off_requests = 0;
        req.valid = 1'b0;
        req.start_x = '0;
        req.start_y = '0;
        req.end_x = '0;
        req.end_y = '0;
        req.query_x = '0;
        req.query_y = '0;
        rsp.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_queries.push_back(make_query(0, 0, 256, 0, 128, 256));
        pending_queries.push_back(make_query(0, 0, 256, 0, 0, 100));
        pending_queries.push_back(make_query(0, 0, 256, 0, 256, -100));
        pending_queries.push_back(make_query(0, 0, 256, 0, -1, 5));
        pending_queries.push_back(make_query(0, 0, 256, 0, 257, 5));
        pending_queries.push_back(make_query(10, 20, 10, 20, 10, 20));
        pending_queries.push_back(make_query(5, 5, 5, 5, 100, -3));
        pending_queries.push_back(make_query(0, 0, 3, 4, 1, 7));
        pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 32767, -32768));
        pending_queries.push_back(make_query(-32768, 32767, 32767, -32768, -32768, -32768));
        pending_queries.push_back(make_query(-32768, 0, 32767, 0, 0, 32767));
        pending_queries.push_back(make_query(0, -32768, 0, 32767, -32768, 0));
        pending_queries.push_back(make_query(-32768, -32768, 32767, -32767, 0, 32767));
        pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 0, 0));
        pending_queries.push_back(make_query(1, 0, 0, 1, 0, 0));
        pending_queries.push_back(make_query(0, 0, 1, 1, 1, 0));
        pending_queries.push_back(make_query(-1, -1, 1, 1, -1, 1));
        pending_queries.push_back(make_query(32767, 32767, -32768, -32768, 32767, 32767));
        wait_drained();

        receiver_quiet = 1'b1;
        sender_quiet = 1'b1;
        for (int i = 0; i < 400; i++)
        begin
            pending_queries.push_back(random_query());
        end
        wait_drained();
        receiver_quiet = 1'b0;

        hold_off_requests = 1;
        for (int i = 0; i < 200; i++)
        begin
            pending_queries.push_back(random_query());
        end
        wait_drained();
        sender_quiet = 1'b0;

        sender_busy_idle = 1'b1;
        repeat (50) @(posedge clk);
        sender_busy_idle = 1'b0;

        for (int i = 0; i < 950; i++)
        begin
            pending_queries.push_back(random_query());
        end
        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/psd_pkg.sv
rtl/psd_req_if.sv
rtl/psd_rsp_if.sv
rtl/psd_fifo.sv
rtl/psd_front.sv
rtl/psd_back.sv
rtl/point_segment_distance.sv
tb/point_segment_distance_tb.sv
